### design/nsd_pkg.sv
// shared types and constants for the netpbm stream decoder
package nsd_pkg;

	localparam int MaxWidth  = 4096;
	localparam int MaxHeight = 4096;

	localparam logic [16:0] ACC_MAX = 17'h1FFFF;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_PIXEL  = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	localparam logic [2:0] ERR_NONE   = 3'd0;
	localparam logic [2:0] ERR_MAGIC  = 3'd1;
	localparam logic [2:0] ERR_HDRVAL = 3'd2;
	localparam logic [2:0] ERR_LARGE  = 3'd3;
	localparam logic [2:0] ERR_TRUNC  = 3'd4;
	localparam logic [2:0] ERR_CHAR   = 3'd5;
	localparam logic [2:0] ERR_SHORT  = 3'd6;

	// job queued from front to back
	typedef struct packed {
		logic [7:0] byte_value;
		logic       end_of_file;
	} job_t;

	// result item
	typedef struct packed {
		logic       last_pixel;
		logic [2:0] error_code;
		logic [2:0] format_code;
		logic [12:0] image_height;
		logic [12:0] image_width;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [1:0] item_kind;
	} result_t;

	localparam int ResultBits = $bits(result_t);

endpackage

### design/netpbm_stream_decoder.sv
// top level of the netpbm stream decoder
//
// channel | dir | tdata fields (low bit up)                         | tuser
// s_axis  | in  | byte_value[7:0]                                   | -
//         |     | tlast = end_of_file                               |
// m_axis  | out | red, green, blue, image_width, image_height,      | item_kind
//         |     | format_code, error_code, last_pixel (pad to 64)   |
//
// a byte passes through the front queue and then the back part
// a p4 byte expands to up to eight pixels, one per cycle unless output stalls
// a p2 or p3 sample runs a shift-subtract divide by maxval on the byte that
// ends it; a p1 sample makes the parser look at that byte again
// end of file passes an extra end state, and a check state as well when a
// number completes on the last byte, plus the divide for a p2 or p3 sample
// reset clears the queue and the parser to expect magic letter
// a stalled output register holds the parser; the input queue keeps filling
module netpbm_stream_decoder import nsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // byte_value
	input  logic        s_axis_tlast,   // end_of_file
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // red, green, blue, image_width, image_height,
	                                    // format_code, error_code, last_pixel, zero pad
	output logic [1:0]  m_axis_tuser    // item_kind
);

	job_t    in_job, q_job;
	logic    q_valid, q_ready;
	result_t res;

	assign in_job.byte_value  = s_axis_tdata;
	assign in_job.end_of_file = s_axis_tlast;

	// front: byte queue
	nsd_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_job(in_job),
		.q_valid(q_valid), .q_ready(q_ready), .q_job(q_job)
	);

	// back: parser, pixel expansion and result register
	nsd_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_job(q_job),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
	);

	assign m_axis_tuser = res.item_kind;
	assign m_axis_tdata = {7'd0, res.last_pixel, res.error_code, res.format_code,
		res.image_height, res.image_width, res.blue, res.green, res.red};

endmodule

### design/nsd_front.sv
// input stage: takes bytes and queues them for the parser
module nsd_front import nsd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  job_t       in_job,
	output logic       q_valid,
	input  logic       q_ready,
	output job_t       q_job
);

	job_t       mem_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	logic       push, pop;

	assign in_ready = (cnt_q != 3'd4);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 3'd0);
	assign pop      = q_valid && q_ready;
	assign q_job    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 2'd0;
			rd_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			if (push) wr_q <= wr_q + 2'd1;
			if (pop)  rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + {2'b00, push} - {2'b00, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4) else $error("queue count overflow");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != 3'd0) else $error("pop on empty queue");
	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 3'd1) else $error("count slip");

endmodule

### design/nsd_divider.sv
// sequential restoring divider for ascii sample scaling
module nsd_divider import nsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [24:0] dividend,
	input  logic [15:0] divisor,
	output logic        busy,
	output logic [7:0]  quotient
);

	logic [24:0] quo_q;
	logic [16:0] rem_q;
	logic [15:0] div_q;
	logic [4:0]  step_q;
	logic [17:0] trial;
	logic [16:0] shifted;

	assign busy     = (step_q != 5'd0);
	assign quotient = quo_q[7:0];
	assign shifted  = {rem_q[15:0], quo_q[24]};
	assign trial    = {1'b0, shifted} - {2'b00, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 5'd0;
		end else if (start) begin
			step_q <= 5'd25;
		end else if (busy) begin
			step_q <= step_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= 17'd0;
			div_q <= (divisor == 16'd0) ? 16'd1 : divisor;
		end else if (busy) begin
			if (!trial[17]) begin
				rem_q <= trial[16:0];
				quo_q <= {quo_q[23:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[23:0], 1'b0};
			end
		end
	end

endmodule

### design/nsd_back.sv
// parser and pixel generator
module nsd_back import nsd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_valid,
	output logic    q_ready,
	input  job_t    q_job,
	output logic    res_valid,
	input  logic    res_ready,
	output result_t res
);

	typedef enum logic [5:0] {
		ST_MAGIC_P = 6'b000001,
		ST_MAGIC_D = 6'b000010,
		ST_HEADER  = 6'b000100,
		ST_DATA    = 6'b001000,
		ST_DONE    = 6'b010000,
		ST_ERROR   = 6'b100000
	} phase_t;

	// sequencer steps for one job
	typedef enum logic [6:0] {
		SQ_IDLE   = 7'b0000001,
		SQ_P4     = 7'b0000010,
		SQ_DIV    = 7'b0000100,
		SQ_EOF    = 7'b0001000,
		SQ_EOFDIV = 7'b0010000,
		SQ_EOFCHK = 7'b0100000,
		SQ_HDRDAT = 7'b1000000
	} seq_t;

	phase_t      phase_q;
	seq_t        seq_q;
	logic [2:0]  fmt_q;
	logic [1:0]  fidx_q;
	logic [16:0] acc_q;
	logic        innum_q, incom_q;
	logic [12:0] w_q, h_q, col_q, row_q;
	logic [15:0] maxv_q;
	logic [1:0]  comp_q;
	logic [7:0]  hr_q, hg_q, byte_q;
	logic [2:0]  seen_q;
	logic [3:0]  bit_q, nbit_q;
	logic        eof_q;

	logic    out_full_q;
	result_t out_q;

	logic        div_start, div_busy;
	logic [24:0] div_num;
	logic [7:0]  div_quo;

	nsd_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_num),
		.divisor(maxv_q), .busy(div_busy), .quotient(div_quo)
	);

	assign res_valid = out_full_q;
	assign res       = out_q;

	logic can_emit;
	assign can_emit = !out_full_q || res_ready;
	assign q_ready  = (seq_q == SQ_IDLE) && can_emit;

	function automatic logic is_ws(input logic [7:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
	endfunction
	function automatic logic is_dig(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction
	function automatic logic [16:0] acc_next(input logic [16:0] a, input logic [7:0] c);
		logic [20:0] t;
		t = {a, 3'b000} + {3'b000, a, 1'b0} + {17'd0, c[3:0]};
		return (t > {4'd0, ACC_MAX}) ? ACC_MAX : t[16:0];
	endfunction

	// combinational next-state for one pass
	phase_t      n_phase;
	seq_t        n_seq;
	logic [2:0]  n_fmt;
	logic [1:0]  n_fidx;
	logic [16:0] n_acc;
	logic        n_innum, n_incom;
	logic [12:0] n_w, n_h, n_col, n_row;
	logic [15:0] n_maxv;
	logic [1:0]  n_comp;
	logic [7:0]  n_hr, n_hg, n_byte;
	logic [2:0]  n_seen;
	logic [3:0]  n_bit, n_nbit;
	logic        n_eof;
	logic        emit;
	result_t     e;
	logic        do_rst;

	logic [7:0]  c;
	logic [16:0] flim;
	logic [12:0] rem_cols;
	logic        pix_last;

	always_comb begin
		n_phase = phase_q; n_seq = seq_q; n_fmt = fmt_q; n_fidx = fidx_q;
		n_acc = acc_q; n_innum = innum_q; n_incom = incom_q;
		n_w = w_q; n_h = h_q; n_col = col_q; n_row = row_q; n_maxv = maxv_q;
		n_comp = comp_q; n_hr = hr_q; n_hg = hg_q; n_byte = byte_q;
		n_seen = seen_q; n_bit = bit_q; n_nbit = nbit_q; n_eof = eof_q;
		emit = 1'b0; e = '0; do_rst = 1'b0;
		div_start = 1'b0; div_num = '0;
		c = byte_q; flim = 17'd65535; rem_cols = '0; pix_last = 1'b0;
		e.format_code = fmt_q;

		case (seq_q)
			SQ_IDLE: begin
				if (q_valid && can_emit) begin
					c = q_job.byte_value;
					n_byte = c;
					n_eof = q_job.end_of_file;
					if (seen_q != 3'd7) n_seen = seen_q + 3'd1;
					n_seq = q_job.end_of_file ? SQ_EOF : SQ_IDLE;
					case (phase_q)
						ST_MAGIC_P: begin
							if (c == 8'h50) n_phase = ST_MAGIC_D;
							else begin
								emit = 1'b1; e.item_kind = KIND_ERROR;
								e.error_code = ERR_MAGIC; n_phase = ST_ERROR;
							end
						end
						ST_MAGIC_D: begin
							if (c >= 8'h31 && c <= 8'h36) begin
								n_fmt = c[2:0]; n_phase = ST_HEADER;
							end else begin
								emit = 1'b1; e.item_kind = KIND_ERROR;
								e.error_code = ERR_MAGIC; n_phase = ST_ERROR;
							end
						end
						ST_HEADER: begin
							if (incom_q) begin
								if (c == 8'h0A) n_incom = 1'b0;
							end else if (innum_q && is_dig(c)) begin
								n_acc = acc_next(acc_q, c);
							end else if (innum_q) begin
								// finish a header field
								n_innum = 1'b0; n_acc = '0;
								flim = (fidx_q == 2'd0) ? 17'(MaxWidth) :
								       (fidx_q == 2'd1) ? 17'(MaxHeight) : 17'd65535;
								if (acc_q == 17'd0 || acc_q > flim) begin
									emit = 1'b1; e.item_kind = KIND_ERROR;
									e.error_code = (acc_q == 17'd0) ? ERR_HDRVAL : ERR_LARGE;
									n_phase = ST_ERROR;
								end else begin
									if (fidx_q == 2'd0) n_w = acc_q[12:0];
									else if (fidx_q == 2'd1) n_h = acc_q[12:0];
									else n_maxv = acc_q[15:0];
									n_fidx = fidx_q + 2'd1;
									if (fidx_q == 2'd2 ||
									    (fidx_q == 2'd1 && (fmt_q == 3'd1 || fmt_q == 3'd4))) begin
										if (fmt_q == 3'd1 || fmt_q == 3'd4) n_maxv = 16'd1;
										emit = 1'b1; e.item_kind = KIND_HEADER;
										e.image_width  = (fidx_q == 2'd0) ? acc_q[12:0] : w_q;
										e.image_height = (fidx_q == 2'd1) ? acc_q[12:0] : h_q;
										n_phase = ST_DATA; n_col = '0; n_row = '0;
										n_comp = '0;
										// a non-terminator byte is the first data byte
										if (!(c == 8'h20 || c == 8'h0A || c == 8'h0D))
											n_seq = SQ_HDRDAT;
									end else if (is_ws(c)) begin
									end else if (c == 8'h23) n_incom = 1'b1;
									else if (is_dig(c)) begin
										n_innum = 1'b1; n_acc = {13'd0, c[3:0]};
									end else begin
										emit = 1'b1; e.item_kind = KIND_ERROR;
										e.error_code = ERR_HDRVAL; n_phase = ST_ERROR;
									end
								end
							end else if (is_ws(c)) begin
							end else if (c == 8'h23) n_incom = 1'b1;
							else if (is_dig(c)) begin
								n_innum = 1'b1; n_acc = {13'd0, c[3:0]};
							end else begin
								emit = 1'b1; e.item_kind = KIND_ERROR;
								e.error_code = ERR_HDRVAL; n_phase = ST_ERROR;
							end
						end
						ST_DATA: begin
							n_seq = SQ_HDRDAT;
						end
						default: ;
					endcase
				end
			end
			SQ_HDRDAT: begin
				// data byte handling, one result at most per cycle
				if (can_emit) begin
					n_seq = eof_q ? SQ_EOF : SQ_IDLE;
					pix_last = (row_q + 13'd1 == h_q) && (col_q + 13'd1 == w_q);
					case (fmt_q)
						3'd6: begin
							if (comp_q == 2'd0) begin n_hr = c; n_comp = 2'd1; end
							else if (comp_q == 2'd1) begin n_hg = c; n_comp = 2'd2; end
							else begin
								n_comp = 2'd0; emit = 1'b1; e.item_kind = KIND_PIXEL;
								e.red = hr_q; e.green = hg_q; e.blue = c;
							end
						end
						3'd5: begin
							emit = 1'b1; e.item_kind = KIND_PIXEL;
							e.red = c; e.green = c; e.blue = c;
						end
						3'd4: begin
							rem_cols = w_q - col_q;
							n_nbit = (rem_cols > 13'd8) ? 4'd8 : rem_cols[3:0];
							n_bit = 4'd0;
							n_seq = SQ_P4;
						end
						default: begin
							if (incom_q) begin
								if (c == 8'h0A) n_incom = 1'b0;
							end else if (innum_q && is_dig(c)) begin
								n_acc = acc_next(acc_q, c);
							end else if (innum_q) begin
								n_innum = 1'b0;
								if (fmt_q == 3'd1) begin
									emit = 1'b1; e.item_kind = KIND_PIXEL;
									e.red = (acc_q != 0) ? 8'd0 : 8'd255;
									e.green = e.red; e.blue = e.red;
									n_acc = '0;
									// look at the byte that ended the number again
									if (!pix_last) n_seq = SQ_HDRDAT;
								end else begin
									div_start = 1'b1;
									div_num = {acc_q, 8'd0} - {8'd0, acc_q};
									n_acc = '0;
									n_seq = SQ_DIV;
								end
							end else if (is_ws(c)) begin
							end else if (c == 8'h23) n_incom = 1'b1;
							else if (is_dig(c)) begin
								n_innum = 1'b1; n_acc = {13'd0, c[3:0]};
							end else begin
								emit = 1'b1; e.item_kind = KIND_ERROR;
								e.error_code = ERR_CHAR; n_phase = ST_ERROR;
							end
						end
					endcase
				end
			end
			SQ_P4: begin
				if (can_emit) begin
					if (bit_q == nbit_q || phase_q != ST_DATA) begin
						n_seq = eof_q ? SQ_EOF : SQ_IDLE;
					end else begin
						pix_last = (row_q + 13'd1 == h_q) && (col_q + 13'd1 == w_q);
						emit = 1'b1; e.item_kind = KIND_PIXEL;
						e.red = byte_q[3'd7 - bit_q[2:0]] ? 8'd0 : 8'd255;
						e.green = e.red; e.blue = e.red;
						n_bit = bit_q + 4'd1;
					end
				end
			end
			SQ_DIV, SQ_EOFDIV: begin
				if (!div_busy && !div_start && can_emit) begin
					if (fmt_q == 3'd2) begin
						pix_last = (row_q + 13'd1 == h_q) && (col_q + 13'd1 == w_q);
						emit = 1'b1; e.item_kind = KIND_PIXEL;
						e.red = div_quo; e.green = div_quo; e.blue = div_quo;
					end else if (comp_q == 2'd0) begin n_hr = div_quo; n_comp = 2'd1; end
					else if (comp_q == 2'd1) begin n_hg = div_quo; n_comp = 2'd2; end
					else begin
						pix_last = (row_q + 13'd1 == h_q) && (col_q + 13'd1 == w_q);
						n_comp = 2'd0; emit = 1'b1; e.item_kind = KIND_PIXEL;
						e.red = hr_q; e.green = hg_q; e.blue = div_quo;
					end
					if (seq_q == SQ_EOFDIV) n_seq = SQ_EOFCHK;
					else if (phase_q != ST_DATA || pix_last) n_seq = eof_q ? SQ_EOF : SQ_IDLE;
					else begin
						// continue with the byte that ended the number
						n_seq = SQ_HDRDAT; n_innum = 1'b0;
					end
				end
			end
			SQ_EOF: begin
				if (can_emit) begin
					n_seq = SQ_IDLE; do_rst = 1'b1;
					if (phase_q == ST_ERROR) ;
					else if (seen_q < 3'd7) begin
						emit = 1'b1; e.item_kind = KIND_ERROR; e.error_code = ERR_SHORT;
					end else if (phase_q == ST_HEADER) begin
						flim = (fidx_q == 2'd0) ? 17'(MaxWidth) :
						       (fidx_q == 2'd1) ? 17'(MaxHeight) : 17'd65535;
						emit = 1'b1; e.item_kind = KIND_ERROR;
						if (innum_q && acc_q == 17'd0) e.error_code = ERR_HDRVAL;
						else if (innum_q && acc_q > flim) e.error_code = ERR_LARGE;
						else if (innum_q && (fidx_q == 2'd2 ||
						         (fidx_q == 2'd1 && (fmt_q == 3'd1 || fmt_q == 3'd4)))) begin
							// header completes on the last byte, then data is missing
							e.item_kind = KIND_HEADER;
							e.image_width  = (fidx_q == 2'd0) ? acc_q[12:0] : w_q;
							e.image_height = (fidx_q == 2'd1) ? acc_q[12:0] : h_q;
							do_rst = 1'b0; n_seq = SQ_EOFCHK;
							n_phase = ST_DATA; n_innum = 1'b0;
						end else e.error_code = ERR_HDRVAL;
					end else if (phase_q == ST_DATA) begin
						if (innum_q && fmt_q <= 3'd3) begin
							n_innum = 1'b0; do_rst = 1'b0;
							if (fmt_q == 3'd1) begin
								pix_last = (row_q + 13'd1 == h_q) && (col_q + 13'd1 == w_q);
								emit = 1'b1; e.item_kind = KIND_PIXEL;
								e.red = (acc_q != 0) ? 8'd0 : 8'd255;
								e.green = e.red; e.blue = e.red;
								n_seq = SQ_EOFCHK;
							end else begin
								div_start = 1'b1;
								div_num = {acc_q, 8'd0} - {8'd0, acc_q};
								n_seq = SQ_EOFDIV;
							end
						end else begin
							emit = 1'b1; e.item_kind = KIND_ERROR; e.error_code = ERR_TRUNC;
						end
					end else if (phase_q != ST_DONE) begin
						emit = 1'b1; e.item_kind = KIND_ERROR; e.error_code = ERR_SHORT;
					end
				end
			end
			SQ_EOFCHK: begin
				if (can_emit) begin
					n_seq = SQ_IDLE; do_rst = 1'b1;
					if (phase_q == ST_DATA) begin
						emit = 1'b1; e.item_kind = KIND_ERROR; e.error_code = ERR_TRUNC;
					end
				end
			end
			default: n_seq = SQ_IDLE;
		endcase

		// pixel bookkeeping
		if (emit && e.item_kind == KIND_PIXEL) begin
			e.last_pixel = pix_last;
			if (col_q + 13'd1 >= w_q) begin n_col = '0; n_row = row_q + 13'd1; end
			else n_col = col_q + 13'd1;
			if (pix_last) n_phase = ST_DONE;
		end
		if (emit && e.item_kind == KIND_ERROR) n_phase = ST_ERROR;

		if (do_rst) begin
			n_phase = ST_MAGIC_P; n_fmt = '0; n_fidx = '0; n_acc = '0;
			n_innum = 1'b0; n_incom = 1'b0; n_w = '0; n_h = '0; n_maxv = 16'd1;
			n_col = '0; n_row = '0; n_comp = '0; n_hr = '0; n_hg = '0;
			n_seen = '0; n_eof = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ST_MAGIC_P; seq_q <= SQ_IDLE; fmt_q <= '0; fidx_q <= '0;
			acc_q <= '0; innum_q <= 1'b0; incom_q <= 1'b0; w_q <= '0; h_q <= '0;
			col_q <= '0; row_q <= '0; maxv_q <= 16'd1; comp_q <= '0;
			hr_q <= '0; hg_q <= '0; byte_q <= '0; seen_q <= '0;
			bit_q <= '0; nbit_q <= '0; eof_q <= 1'b0; out_full_q <= 1'b0;
		end else begin
			phase_q <= n_phase; seq_q <= n_seq; fmt_q <= n_fmt; fidx_q <= n_fidx;
			acc_q <= n_acc; innum_q <= n_innum; incom_q <= n_incom; w_q <= n_w;
			h_q <= n_h; col_q <= n_col; row_q <= n_row; maxv_q <= n_maxv;
			comp_q <= n_comp; hr_q <= n_hr; hg_q <= n_hg; byte_q <= n_byte;
			seen_q <= n_seen; bit_q <= n_bit; nbit_q <= n_nbit; eof_q <= n_eof;
			if (emit) out_full_q <= 1'b1;
			else if (res_ready) out_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) out_q <= e;
	end

	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> can_emit) else $error("result overwritten");
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_ready |-> seq_q == SQ_IDLE) else $error("job taken while busy");
	a_err_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && e.item_kind == KIND_ERROR && !do_rst) |=> phase_q == ST_ERROR)
		else $error("error without error phase");

endmodule

### dv/tb.sv
// testbench for the netpbm stream decoder: byte stimulus, own decoder model, result check
`timescale 1ns / 1ps
module tb import nsd_pkg::*; ();

	typedef enum logic [2:0] {
		ST_MAGIC_P, ST_MAGIC_D, ST_HEADER, ST_DATA, ST_DONE, ST_ERROR
	} parse_state_e;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [12:0] width;
		logic [12:0] height;
		logic [2:0]  format;
		logic [2:0]  err;
		logic        last;
	} pnm_item_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // byte_value
	logic        s_axis_tlast;   // end_of_file
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [63:0] m_axis_tdata;   // red, green, blue, image_width, image_height,
	                             // format_code, error_code, last_pixel, zero pad
	logic [1:0]  m_axis_tuser;   // item_kind

	netpbm_stream_decoder u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	// decoder model state
	parse_state_e st;
	int unsigned  fmt, fld, acc, innum, incom, wid, hgt, mxv, col, row, comp, hr, hg, nbytes;
	pnm_item_t    pixel_queue[$];
	int unsigned  mismatches;
	bit           quiet;        // no idling in the final part
	bit           rx_stall_on;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic void model_reset();
		st = ST_MAGIC_P; fmt = 0; fld = 0; acc = 0; innum = 0; incom = 0;
		wid = 0; hgt = 0; mxv = 1; col = 0; row = 0; comp = 0; hr = 0; hg = 0;
		nbytes = 0;
	endfunction

	function automatic void push(logic [1:0] k, int unsigned r, int unsigned g,
		int unsigned b, int unsigned w, int unsigned h, logic [2:0] e, bit l);
		pnm_item_t it;
		it.kind = k; it.red = r[7:0]; it.green = g[7:0]; it.blue = b[7:0];
		it.width = w[12:0]; it.height = h[12:0]; it.format = fmt[2:0];
		it.err = e; it.last = l;
		pixel_queue.push_back(it);
	endfunction

	function automatic void raise(logic [2:0] e);
		push(KIND_ERROR, 0, 0, 0, 0, 0, e, 1'b0);
		st = ST_ERROR;
	endfunction

	function automatic void emit_pixel(int unsigned r, int unsigned g, int unsigned b);
		bit l;
		l = (row + 1 == hgt) && (col + 1 == wid);
		push(KIND_PIXEL, r, g, b, 0, 0, ERR_NONE, l);
		col++;
		if (col >= wid) begin
			col = 0;
			row++;
		end
		if (l)
			st = ST_DONE;
	endfunction

	function automatic bit is_space(int unsigned c);
		return c == 32 || c == 9 || c == 10 || c == 13;
	endfunction

	function automatic bit is_num(int unsigned c);
		return c >= 48 && c <= 57;
	endfunction

	function automatic void add_digit(int unsigned c);
		acc = acc * 10 + (c - 48);
		if (acc > ACC_MAX)
			acc = ACC_MAX;
	endfunction

	function automatic bit bitmap_fmt();
		return fmt == 1 || fmt == 4;
	endfunction

	// 0 more fields, 1 header done, 2 failed
	function automatic int close_field();
		int unsigned v, lim;
		v = acc;
		lim = fld == 0 ? MaxWidth : fld == 1 ? MaxHeight : 65535;
		innum = 0;
		acc = 0;
		if (v == 0) begin
			raise(ERR_HDRVAL);
			return 2;
		end
		if (v > lim) begin
			raise(ERR_LARGE);
			return 2;
		end
		if (fld == 0) wid = v;
		else if (fld == 1) hgt = v;
		else mxv = v;
		fld++;
		if (fld == 3 || (fld == 2 && bitmap_fmt())) begin
			if (bitmap_fmt())
				mxv = 1;
			push(KIND_HEADER, 0, 0, 0, wid, hgt, ERR_NONE, 1'b0);
			st = ST_DATA; col = 0; row = 0; comp = 0;
			return 1;
		end
		return 0;
	endfunction

	function automatic int unsigned rescale(int unsigned v);
		longint unsigned p;
		p = longint'(v) * 255 / (mxv != 0 ? mxv : 1);
		return p[7:0];
	endfunction

	function automatic void text_sample(int unsigned v);
		int unsigned s;
		if (fmt == 1) begin
			s = v != 0 ? 0 : 255;
			emit_pixel(s, s, s);
		end else begin
			s = rescale(v);
			if (fmt == 2)
				emit_pixel(s, s, s);
			else if (comp == 0) begin
				hr = s; comp = 1;
			end else if (comp == 1) begin
				hg = s; comp = 2;
			end else begin
				comp = 0;
				emit_pixel(hr, hg, s);
			end
		end
	endfunction

	function automatic void text_byte(int unsigned c);
		if (incom) begin
			if (c == 10) incom = 0;
			return;
		end
		if (innum) begin
			if (is_num(c)) begin
				add_digit(c);
				return;
			end
			innum = 0;
			text_sample(acc);
			acc = 0;
			if (st != ST_DATA) return;
		end
		if (is_space(c)) return;
		if (c == 35) begin
			incom = 1;
			return;
		end
		if (is_num(c)) begin
			innum = 1;
			acc = c - 48;
			return;
		end
		raise(ERR_CHAR);
	endfunction

	function automatic void raster_byte(int unsigned c);
		int unsigned n, v;
		case (fmt)
			6: begin
				if (comp == 0) begin
					hr = c; comp = 1;
				end else if (comp == 1) begin
					hg = c; comp = 2;
				end else begin
					comp = 0;
					emit_pixel(hr, hg, c);
				end
			end
			5: emit_pixel(c, c, c);
			4: begin
				n = wid - col;
				if (n > 8) n = 8;
				for (int i = 0; i < n && st == ST_DATA; i++) begin
					v = ((c >> (7 - i)) & 1) ? 0 : 255;
					emit_pixel(v, v, v);
				end
			end
			default: text_byte(c);
		endcase
	endfunction

	function automatic void header_byte(int unsigned c);
		int r;
		if (incom) begin
			if (c == 10) incom = 0;
			return;
		end
		if (innum) begin
			if (is_num(c)) begin
				add_digit(c);
				return;
			end
			r = close_field();
			if (r == 2) return;
			if (r == 1) begin
				if (c == 32 || c == 10 || c == 13) return;
				raster_byte(c);
				return;
			end
		end
		if (is_space(c)) return;
		if (c == 35) begin
			incom = 1;
			return;
		end
		if (is_num(c)) begin
			innum = 1;
			acc = c - 48;
			return;
		end
		raise(ERR_HDRVAL);
	endfunction

	function automatic void file_end();
		if (st == ST_ERROR) return;
		if (nbytes < 7) begin
			raise(ERR_SHORT);
			return;
		end
		if (st == ST_HEADER) begin
			if (innum && close_field() == 2) return;
			if (st == ST_HEADER) begin
				raise(ERR_HDRVAL);
				return;
			end
		end
		if (st == ST_DATA) begin
			if (innum && fmt <= 3) begin
				innum = 0;
				text_sample(acc);
			end
			if (st == ST_DATA) raise(ERR_TRUNC);
			return;
		end
		if (st != ST_DONE) raise(ERR_SHORT);
	endfunction

	function automatic void decode_byte(int unsigned c, bit eof);
		if (nbytes < 7) nbytes++;
		case (st)
			ST_MAGIC_P: if (c == 80) st = ST_MAGIC_D; else raise(ERR_MAGIC);
			ST_MAGIC_D: begin
				if (c >= 49 && c <= 54) begin
					fmt = c - 48;
					st = ST_HEADER;
				end else
					raise(ERR_MAGIC);
			end
			ST_HEADER: header_byte(c);
			ST_DATA:   raster_byte(c);
			default: ;
		endcase
		if (eof) begin
			file_end();
			model_reset();
		end
	endfunction

	// sends one byte, sometimes with a random gap before it unless quiet
	task automatic send_byte(input logic [7:0] b, input bit eof);
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 11);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= eof;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		decode_byte(b, eof);
	endtask

	task automatic send_text(input string s, input bit close_file);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], close_file && i == s.len() - 1);
	endtask

	task automatic go_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pixel_queue.size() != 0) @(posedge clk);
	endtask

	// output stall driver: bursts of back-pressure
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 7) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	// result checker
	always @(posedge clk) begin
		pnm_item_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.kind   = m_axis_tuser;
			got.red    = m_axis_tdata[7:0];
			got.green  = m_axis_tdata[15:8];
			got.blue   = m_axis_tdata[23:16];
			got.width  = m_axis_tdata[36:24];
			got.height = m_axis_tdata[49:37];
			got.format = m_axis_tdata[52:50];
			got.err    = m_axis_tdata[55:53];
			got.last   = m_axis_tdata[56];
			if (pixel_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transfer: %p", got);
			end else begin
				want = pixel_queue.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p actual %p", want, got);
				end
			end
		end
	end

	task automatic test_formats();
		send_text("P6 2 1 255\n", 0);
		send_byte(8'h00, 0); send_byte(8'hFF, 0); send_byte(8'h80, 0);
		send_byte(8'h7F, 0); send_byte(8'h01, 0); send_byte(8'hFE, 1);
		send_text("P5\n#c x\n3 1\t7\rAUZ", 1);
		send_text("P4 10 2\n", 0);
		send_byte(8'hA5, 0); send_byte(8'hC0, 0); send_byte(8'h5A, 0);
		send_byte(8'h40, 1);
		send_text("P3 1 1 65535 65535 0 #x\n 131071999\n", 1);
		send_text("P2 2 1 7 7 3", 1);
		send_text("P1 3 1 1 0 9 ", 1);
		go_idle();
	endtask

	task automatic test_errors();
		send_text("Q3 1 1 1 1", 1);          // bad letter
		send_text("P7 1 1 1 1", 1);          // bad digit
		send_text("P5 0 1 255 x", 1);        // zero width
		send_text("P5 4097 1 255 x", 1);     // too wide
		send_text("P5 1 1 65536 x", 1);      // maxval too large
		send_text("P5 x 1 255 x", 1);        // non-digit header
		send_text("P2 2 2 9 1 2 z 3", 1);    // bad ascii
		send_text("P5 2 2 255 ab", 1);       // truncated
		send_text("P5 1", 1);                // short
		send_text("P5 1 1", 1);              // short, header unfinished
		send_byte(8'h50, 1);
		go_idle();
	endtask

	function automatic string num_text(int unsigned v);
		return $sformatf("%0d", v);
	endfunction

	task automatic test_random(input int unsigned budget);
		int unsigned sent, f, w, h, m, n, kind;
		string hd;
		sent = 0;
		while (sent < budget) begin
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				// noise file
				n = $urandom_range(1, 12);
				for (int i = 0; i < n; i++)
					send_byte(8'($urandom_range(0, 255)), i == n - 1);
				sent += n;
				continue;
			end
			f = $urandom_range(1, 6);
			w = $urandom_range(1, 4);
			h = $urandom_range(1, 3);
			m = $urandom_range(0, 3) == 0 ? $urandom_range(1, 65535) : $urandom_range(1, 255);
			if (f == 5 || f == 6) m = $urandom_range(1, 255);
			hd = {"P", num_text(f),
				$urandom_range(0, 1) ? string'(" ") : string'("\n#q\n"),
				num_text(w), " ", num_text(h)};
			if (!(f == 1 || f == 4)) hd = {hd, " ", num_text(m)};
			hd = {hd, "\n"};
			send_text(hd, 0);
			sent += hd.len();
			n = f == 6 ? 3 * w * h : f == 5 ? w * h : f == 4 ? ((w + 7) / 8) * h :
				(f == 3 ? 3 : 1) * w * h;
			if (kind == 1 && n > 1) n = $urandom_range(1, n - 1);  // truncated
			for (int i = 0; i < n; i++) begin
				if (f >= 4) begin
					send_byte(8'($urandom_range(0, 255)), i == n - 1 && kind != 2);
					sent++;
				end else begin
					hd = {num_text(f == 1 ? $urandom_range(0, 2) :
						$urandom_range(0, 1) ? m : $urandom_range(0, m)),
						$urandom_range(0, 1) ? " " : "\t"};
					if (kind == 3 && i == n - 1) hd = {hd, "!"};
					send_text(hd, i == n - 1 && kind != 2);
					sent += hd.len();
				end
			end
			if (kind == 2) begin
				send_byte(8'($urandom_range(0, 255)), 1);
				sent++;
			end
		end
	endtask

	initial begin
		mismatches = 0;
		quiet = 0;
		model_reset();
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_formats();
		test_errors();
		test_random(130);
		go_idle();
		quiet = 1;
		test_random(50);
		go_idle();
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#4ms;
		$display("Mismatches found");
		$finish;
	end

endmodule
